// ===== design/fcw_pkg.sv =====
// ----------------------------------------------------------------------------
// fcw_pkg: shared types and constants of the FAT12 cluster chain walker
// Transaction payloads, opcodes, register indexes and walker states.
// ----------------------------------------------------------------------------
`default_nettype none

package fcw_pkg;

  // Fixed geometry constants of the file system
  localparam int unsigned SECTOR_SHIFT       = 9;   // 512-byte sectors
  localparam logic [15:0] FIRST_DATA_CLUSTER = 16'd2;
  localparam logic [15:0] CHAIN_END          = 16'hFF8;
  localparam logic [7:0]  NIBBLE_MASK        = 8'h0F;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_CONT  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_SPC    = 2'd1,
    CFG_DSTART = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_index_t;

  // Walker states
  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [12:0] table_address;
    logic [7:0]  table_byte;
    logic [15:0] start_cluster;
    logic [31:0] file_size;
  } in_item_t;

  typedef struct packed {
    logic        segment_valid;
    logic [31:0] segment_offset;
    logic [16:0] segment_length;
    logic        last;
    logic [31:0] total_read;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/fcw_ram.sv =====
// ----------------------------------------------------------------------------
// fcw_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]        rdata_a,
  input  wire [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]        rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== design/fat12_cluster_chain_walker.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker: walks FAT12 cluster chains into read segments
// A start or continue reads its FAT pair on acceptance in S_IDLE; S_CALC then registers
// the result. No transaction is taken in S_CALC, which waits while a result is stalled;
// loads and unused opcodes stay in S_IDLE. Sync active-low reset; FAT RAM no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cluster_chain_walker
  import fcw_pkg::*;
#(
  parameter int TABLE_BYTES = 8192
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire        out_ready,
  output out_item_t  out_data,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [23:0] cfg_data
);

  localparam int AW = $clog2(TABLE_BYTES);

  // Configuration registers
  logic        enable_r;
  logic [7:0]  spc_r;
  logic [23:0] dstart_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      spc_r    <= 8'd1;
      dstart_r <= 24'd0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ENABLE: enable_r <= cfg_data[0];
        CFG_SPC:    spc_r    <= cfg_data[7:0];
        CFG_DSTART: dstart_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Walk state
  state_t      state_r, state_nxt;
  logic [15:0] cur_cluster_r, cur_cluster_nxt;
  logic [31:0] done_r, done_nxt;
  logic [31:0] target_r, target_nxt;
  logic        active_r, active_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic in_fire;
  logic calc_fire;
  assign in_fire   = in_valid && in_ready;
  assign calc_fire = (state_r == S_CALC) && (!out_valid_r || out_ready);

  // FAT byte pair index of a cluster: floor(cluster * 3 / 2).
  logic [15:0] rd_cluster;
  logic [17:0] idx_sum;
  logic [16:0] idx_lo;
  logic [17:0] idx_hi;
  logic        lo_in_range, hi_in_range;

  assign rd_cluster = (state_r == S_IDLE && opcode_t'(in_data.opcode) == OP_START) ?
                      in_data.start_cluster : cur_cluster_r;
  assign idx_sum    = {1'b0, rd_cluster, 1'b0} + {2'b0, rd_cluster};
  assign idx_lo     = idx_sum[17:1];
  assign idx_hi     = {1'b0, idx_lo} + 18'd1;
  assign lo_in_range = 32'(idx_lo) < TABLE_BYTES;
  assign hi_in_range = 32'(idx_hi) < TABLE_BYTES;

  // FAT store
  logic       ram_we;
  logic [7:0] rd_lo, rd_hi;

  assign ram_we = in_fire && opcode_t'(in_data.opcode) == OP_LOAD &&
                  32'(in_data.table_address) < TABLE_BYTES;

  fcw_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_fat_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (in_data.table_address[AW-1:0]),
    .wdata   (in_data.table_byte),
    .raddr_a (idx_lo[AW-1:0]),
    .rdata_a (rd_lo),
    .raddr_b (idx_hi[AW-1:0]),
    .rdata_b (rd_hi)
  );

  // Segment arithmetic on the registered walk state.
  logic        geometry_ok, cur_ok, nxt_ok, seg_ok;
  logic [7:0]  lo_b, hi_b, hi_nib;
  logic [15:0] nxt_cluster;
  logic [16:0] chunk, seg_len;
  logic [31:0] remaining, done_sum;
  logic [15:0] cluster_rel;
  logic [22:0] prod;
  logic [31:0] seg_off;

  assign geometry_ok = enable_r && (spc_r != 8'd0);
  assign cur_ok      = (cur_cluster_r >= FIRST_DATA_CLUSTER) && (cur_cluster_r < CHAIN_END);
  assign seg_ok      = active_r && geometry_ok && cur_ok && (done_r < target_r);

  assign chunk       = {spc_r, 9'd0};
  assign remaining   = target_r - done_r;
  assign seg_len     = (remaining < {15'd0, chunk}) ? remaining[16:0] : chunk;
  assign done_sum    = done_r + {15'd0, seg_len};
  assign cluster_rel = cur_cluster_r - FIRST_DATA_CLUSTER;
  // Bits above the 32-bit offset fall away, so a 23-bit product is enough.
  assign prod        = 23'(cluster_rel) * 23'(spc_r);
  assign seg_off     = {8'd0, dstart_r} + {prod, {SECTOR_SHIFT{1'b0}}};

  // Unpack the 12-bit entry: odd clusters take the high 12 bits of the pair.
  assign lo_b        = lo_in_range ? rd_lo : 8'd0;
  assign hi_b        = hi_in_range ? rd_hi : 8'd0;
  assign hi_nib      = hi_b & NIBBLE_MASK;
  assign nxt_cluster = cur_cluster_r[0] ? {4'd0, hi_b, lo_b[7:4]} :
                                          {4'd0, hi_nib[3:0], lo_b};
  assign nxt_ok      = (nxt_cluster >= FIRST_DATA_CLUSTER) && (nxt_cluster < CHAIN_END);

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (opcode_t'(in_data.opcode) == OP_START ||
                        opcode_t'(in_data.opcode) == OP_CONT)) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (calc_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and output updates
  always_comb begin
    cur_cluster_nxt = cur_cluster_r;
    done_nxt        = done_r;
    target_nxt      = target_r;
    active_nxt      = active_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_nxt         = out_r;
    in_ready        = (state_r == S_IDLE);

    // A start resets the walk; its checks fall through the common path.
    if (in_fire && opcode_t'(in_data.opcode) == OP_START) begin
      cur_cluster_nxt = in_data.start_cluster;
      done_nxt        = 32'd0;
      target_nxt      = in_data.file_size;
      active_nxt      = 1'b1;
    end

    if (calc_fire) begin
      out_valid_nxt = 1'b1;
      if (seg_ok) begin
        cur_cluster_nxt        = nxt_cluster;
        done_nxt               = done_sum;
        active_nxt             = (done_sum < target_r) && nxt_ok;
        out_nxt.segment_valid  = 1'b1;
        out_nxt.segment_offset = seg_off;
        out_nxt.segment_length = seg_len;
        out_nxt.last           = !((done_sum < target_r) && nxt_ok);
        out_nxt.total_read     = done_sum;
      end else begin
        active_nxt             = 1'b0;
        out_nxt.segment_valid  = 1'b0;
        out_nxt.segment_offset = 32'd0;
        out_nxt.segment_length = 17'd0;
        out_nxt.last           = 1'b1;
        out_nxt.total_read     = done_r;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cur_cluster_r <= 16'd0;
      done_r        <= 32'd0;
      target_r      <= 32'd0;
      active_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cur_cluster_r <= cur_cluster_nxt;
      done_r        <= done_nxt;
      target_r      <= target_nxt;
      active_r      <= active_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== design/fcw_checker.sv =====
// ----------------------------------------------------------------------------
// fcw_checker: port-level checks of the FAT12 cluster chain walker
// Watches the transaction ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fcw_checker
  import fcw_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input in_item_t  in_data,
  input wire       out_valid,
  input wire       out_ready,
  input out_item_t out_data
);

  // An accepted walk step leaves the walker busy in its compute state.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready &&
     (in_data.opcode == OP_START || in_data.opcode == OP_CONT)) |=> !in_ready)
    else $error("walker accepted a transaction during its compute cycle");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // A result without a segment always ends the read and carries no span.
  a_no_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.segment_valid) |->
    (out_data.last && out_data.segment_length == 17'd0 &&
     out_data.segment_offset == 32'd0))
    else $error("empty result carries a span or continues the read");

  // A real segment covers at least one byte and counts it in the total.
  a_seg_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.segment_valid) |->
    (out_data.segment_length != 17'd0 &&
     out_data.total_read >= {15'd0, out_data.segment_length}))
    else $error("segment has no length or exceeds the running total");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind fat12_cluster_chain_walker fcw_checker u_fcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/fat_walk_check_pkg.sv =====
// ----------------------------------------------------------------------------
// fat_walk_check_pkg: segment predictor and checker for the chain walker
// Keeps its own copy of the FAT bytes, the walk state and the geometry
// registers, works out the segment each accepted transaction should produce
// and compares every result of the block against the oldest one due.
// ----------------------------------------------------------------------------
package fat_walk_check_pkg;
  import fcw_pkg::*;

  localparam int FAT_BYTES = 8192;

  class walk_checker;
    // Mirror of the FAT store, with a flag per byte that has been loaded
    logic [7:0]  fat_bytes [FAT_BYTES];
    bit          written [FAT_BYTES];

    // Walk state and geometry registers
    logic [15:0] cur_cluster;
    logic [31:0] done_bytes;
    logic [31:0] size_target;
    bit          walk_on;
    bit          enable_bit;
    logic [7:0]  spc;
    logic [23:0] data_start;

    out_item_t   segments_due [$];
    int          errors;
    int          results_checked;
    int          segments_seen;

    function new();
      foreach (fat_bytes[i]) begin
        fat_bytes[i] = 8'h00;
        written[i]   = 1'b0;
      end
      cur_cluster     = '0;
      done_bytes      = '0;
      size_target     = '0;
      walk_on         = 1'b0;
      enable_bit      = 1'b0;
      spc             = 8'd1;
      data_start      = '0;
      errors          = 0;
      results_checked = 0;
      segments_seen   = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [23:0] value);
      case (idx)
        CFG_ENABLE: enable_bit = value[0];
        CFG_SPC:    spc        = value[7:0];
        CFG_DSTART: data_start = value;
        default: ;
      endcase
    endfunction

    function bit cluster_in_range(logic [15:0] c);
      return (c >= FIRST_DATA_CLUSTER) && (c < CHAIN_END);
    endfunction

    function bit geometry_ok();
      return enable_bit && (spc != 8'd0);
    endfunction

    function logic [7:0] fat_byte(int idx);
      if (idx >= FAT_BYTES) return 8'h00;
      return fat_bytes[idx];
    endfunction

    // Unpack the 12-bit entry of a cluster from its byte pair.
    function logic [15:0] fat_entry(logic [15:0] c);
      int         idx;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] hi_nib;
      idx    = (int'(c) * 3) / 2;
      lo     = fat_byte(idx);
      hi     = fat_byte(idx + 1);
      hi_nib = hi & NIBBLE_MASK;
      if (c[0]) return {4'h0, hi, lo[7:4]};
      return {4'h0, hi_nib[3:0], lo};
    endfunction

    // Cluster whose FAT entry the transaction will read, or -1 if none.
    function int table_lookup(in_item_t it);
      case (it.opcode)
        OP_START: begin
          if (!geometry_ok() || it.file_size == 0 || !cluster_in_range(it.start_cluster))
            return -1;
          return int'(it.start_cluster);
        end
        OP_CONT: begin
          if (!walk_on || !geometry_ok() || !cluster_in_range(cur_cluster) ||
              done_bytes >= size_target)
            return -1;
          return int'(cur_cluster);
        end
        default: return -1;
      endcase
    endfunction

    // Advance the mirrored state by one accepted transaction and queue the
    // segment that it should produce.
    function void note_transaction(in_item_t it);
      out_item_t   want;
      logic [31:0] chunk;
      logic [31:0] remaining;
      logic [31:0] len;
      logic [15:0] nxt;
      want = '0;
      case (it.opcode)
        OP_LOAD: begin
          if (int'(it.table_address) < FAT_BYTES) begin
            fat_bytes[it.table_address] = it.table_byte;
            written[it.table_address]   = 1'b1;
          end
          return;
        end
        OP_NOP: return;
        OP_START: begin
          walk_on     = 1'b0;
          done_bytes  = '0;
          cur_cluster = it.start_cluster;
          size_target = it.file_size;
          if (!geometry_ok() || size_target == 0) begin
            want.last = 1'b1;
            segments_due.push_back(want);
            return;
          end
          walk_on = 1'b1;
        end
        default: ;
      endcase

      // No segment: the walk is over, off, or pointing at a bad cluster
      if (!walk_on || !geometry_ok() || !cluster_in_range(cur_cluster) ||
          done_bytes >= size_target) begin
        walk_on         = 1'b0;
        want.last       = 1'b1;
        want.total_read = done_bytes;
        segments_due.push_back(want);
        return;
      end

      chunk     = 32'(spc) << SECTOR_SHIFT;
      remaining = size_target - done_bytes;
      len       = (remaining < chunk) ? remaining : chunk;
      want.segment_valid  = 1'b1;
      want.segment_offset = 32'(data_start) + 32'(cur_cluster - FIRST_DATA_CLUSTER) * chunk;
      want.segment_length = len[16:0];
      done_bytes  = done_bytes + len;
      nxt         = fat_entry(cur_cluster);
      cur_cluster = nxt;
      walk_on     = (done_bytes < size_target) && cluster_in_range(nxt);
      want.last       = !walk_on;
      want.total_read = done_bytes;
      segments_due.push_back(want);
    endfunction

    function void report_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                 $time, field, want, got);
      end
    endfunction

    function void check_segment(out_item_t got);
      out_item_t want;
      results_checked++;
      if (segments_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: expected none, actual 0x%0h",
                 $time, got);
        return;
      end
      want = segments_due.pop_front();
      if (want.segment_valid) segments_seen++;
      report_field("segment_valid", want.segment_valid, got.segment_valid);
      report_field("segment_offset", want.segment_offset, got.segment_offset);
      report_field("segment_length", want.segment_length, got.segment_length);
      report_field("last", want.last, got.last);
      report_field("total_read", want.total_read, got.total_read);
    endfunction

    function int pending();
      return segments_due.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the FAT12 cluster chain walker
// Loads FAT chains, walks them with start and continue transactions under
// several geometries and handshake patterns, and checks every result field
// against a predictor kept in step with the accepted transactions.
// ----------------------------------------------------------------------------
module tb_top;
  import fcw_pkg::*;
  import fat_walk_check_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int PHASE_ITEMS    = 225;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  cfg_index_t  cfg_index = CFG_ENABLE;
  logic [23:0] cfg_data  = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_toggle   = 1'b0;
  bit hold_ack      = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int items_sent    = 0;

  walk_checker sb;

  always #10 clk = ~clk;

  fat12_cluster_chain_walker #(
    .TABLE_BYTES(FAT_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Check every result transaction as it is accepted.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_segment(out_data);
  end

  // Result side: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_toggle != hold_ack) begin
      hold_ack  <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results pending", $time, sb.pending());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic in_item_t random_item(opcode_t op);
    in_item_t it;
    it.opcode        = op;
    it.table_address = 13'($urandom);
    it.table_byte    = 8'($urandom);
    it.start_cluster = 16'($urandom);
    it.file_size     = $urandom;
    return it;
  endfunction

  function automatic logic [15:0] pick_cluster();
    if ($urandom_range(9) == 0) return 16'($urandom_range(12'hF00, 12'hFF7));
    return 16'($urandom_range(2, 400));
  endfunction

  function automatic logic [11:0] chain_terminator();
    case ($urandom_range(5))
      0: return 12'h000;
      1: return 12'h001;
      2: return 12'hFF8;
      3: return 12'(pick_cluster());
      default: return 12'($urandom_range(12'hFF8, 12'hFFF));
    endcase
  endfunction

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one transaction and hold it until the block takes it.
  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) idle_input();
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_transaction(it);
    items_sent++;
  endtask

  task automatic load_byte(int addr, logic [7:0] value);
    in_item_t it;
    it               = random_item(OP_LOAD);
    it.table_address = 13'(addr);
    it.table_byte    = value;
    send(it);
  endtask

  // Start and continue go through here: any FAT byte the step will read
  // gets loaded first, so the block never sees an unwritten entry.
  task automatic send_walk(in_item_t it);
    int c;
    int idx;
    c = sb.table_lookup(it);
    if (c >= 0) begin
      idx = (c * 3) / 2;
      for (int k = 0; k < 2; k++) begin
        if (!sb.written[idx + k]) load_byte(idx + k, 8'($urandom));
      end
    end
    send(it);
  endtask

  task automatic start_file(logic [15:0] c, logic [31:0] size);
    in_item_t it;
    it               = random_item(OP_START);
    it.start_cluster = c;
    it.file_size     = size;
    send_walk(it);
  endtask

  task automatic continue_file();
    send_walk(random_item(OP_CONT));
  endtask

  // Write one packed 12-bit entry, keeping the neighbor's nibble.
  task automatic set_entry(int c, logic [11:0] v);
    int         idx;
    logic [7:0] b0;
    logic [7:0] b1;
    idx = (c * 3) / 2;
    b0  = sb.written[idx] ? sb.fat_bytes[idx] : 8'($urandom);
    b1  = sb.written[idx + 1] ? sb.fat_bytes[idx + 1] : 8'($urandom);
    if (c % 2 != 0) begin
      b0[7:4] = v[3:0];
      b1      = v[11:4];
    end else begin
      b0      = v[7:0];
      b1[3:0] = v[11:8];
    end
    load_byte(idx, b0);
    load_byte(idx + 1, b1);
  endtask

  // Stop offering and wait until every expected result has come, then let
  // a trailing load settle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Build a short chain in the FAT, then read a file along it.
  task automatic run_chain();
    int          n;
    int          steps;
    int          max_steps;
    logic [15:0] first;
    logic [15:0] cur;
    logic [15:0] nxt;
    logic [31:0] chunk;
    logic [31:0] size;
    n     = $urandom_range(1, 6);
    first = pick_cluster();
    cur   = first;
    repeat (n - 1) begin
      nxt = pick_cluster();
      set_entry(cur, nxt[11:0]);
      cur = nxt;
    end
    set_entry(cur, chain_terminator());
    chunk = 32'(sb.spc) << SECTOR_SHIFT;
    if (chunk == 0) chunk = 32'd512;
    case ($urandom_range(3))
      0: size = n * chunk;
      1: size = $urandom_range(1, n * chunk);
      2: size = $urandom;
      default: size = $urandom_range(1, 3000);
    endcase
    start_file(first, size);
    // Sometimes the walk is abandoned early so the next start drops it.
    max_steps = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : 10;
    steps = 0;
    while (sb.walk_on && steps < max_steps) begin
      if ($urandom_range(9) == 0) send(random_item(OP_NOP));
      continue_file();
      steps++;
    end
    if ($urandom_range(3) == 0) continue_file();
  endtask

  task automatic run_noise();
    case ($urandom_range(5))
      0: load_byte($urandom_range(0, FAT_BYTES - 1), 8'($urandom));
      1: send(random_item(OP_NOP));
      2: start_file(16'($urandom), $urandom);
      3: start_file(pick_cluster(), 32'd0);
      4: continue_file();
      default: start_file(16'($urandom_range(12'hFF8, 16'hFFFF)), $urandom);
    endcase
  endtask

  task automatic run_phase(int idle, int stall, int items);
    int stop_at;
    send_idle_pct = idle;
    stall_pct     = stall;
    stop_at       = items_sent + items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 70) run_chain();
      else run_noise();
      if ($urandom_range(40) == 0) wait_for_results();
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Block still disabled after reset, continue with no walk, unused opcode
    start_file(16'd2, 32'd100);
    continue_file();
    send(random_item(OP_NOP));
    wait_for_results();
    write_reg(CFG_ENABLE, 24'd1);
    write_reg(CFG_SPC, 24'd1);
    write_reg(CFG_DSTART, 24'h001000);
    write_reg(CFG_UNUSED, 24'hFFFFFF);

    // Chain 2 -> 3 -> 5 -> end of chain, plus both ends of the address range
    set_entry(2, 12'd3);
    set_entry(3, 12'd5);
    set_entry(5, 12'hFFF);
    load_byte(FAT_BYTES - 1, 8'hFF);
    load_byte(0, 8'h00);

    // Size runs out in the last cluster
    start_file(16'd2, 32'd1300);
    continue_file();
    continue_file();
    // Zero size and bad first clusters
    start_file(16'd2, 32'd0);
    start_file(16'd0, 32'd10);
    start_file(16'd1, 32'd10);
    start_file(16'hFF8, 32'd10);
    start_file(16'hFFFF, 32'd10);
    // Chain end seen ahead, then a continue with no walk left
    start_file(16'd2, 32'd5000);
    continue_file();
    continue_file();
    continue_file();
    // New start while a walk is running
    start_file(16'd2, 32'd5000);
    start_file(16'd3, 32'd100);

    // Disabled in the middle of a walk
    start_file(16'd2, 32'd5000);
    wait_for_results();
    write_reg(CFG_ENABLE, 24'd0);
    continue_file();
    wait_for_results();
    write_reg(CFG_ENABLE, 24'd1);

    // Zero sectors per cluster counts as invalid geometry
    write_reg(CFG_SPC, 24'd0);
    start_file(16'd2, 32'd5000);
    wait_for_results();

    // 128-sector clusters, highest data start, largest cluster number
    write_reg(CFG_SPC, 24'd128);
    write_reg(CFG_DSTART, 24'hFFFFFF);
    set_entry(12'hFF7, 12'hFF8);
    start_file(16'hFF7, 32'hFFFF_FFFF);
    start_file(16'd2, 32'hFFFF_FFFF);
    continue_file();
    continue_file();
    wait_for_results();

    // Random phase with no idling; the receiver holds off at its start
    write_reg(CFG_SPC, 24'd1);
    write_reg(CFG_DSTART, 24'($urandom));
    hold_toggle <= ~hold_toggle;
    run_phase(0, 0, PHASE_ITEMS);
    wait_for_results();

    write_reg(CFG_SPC, 24'd128);
    write_reg(CFG_DSTART, 24'hFFFFFF);
    run_phase(63, 0, PHASE_ITEMS);
    wait_for_results();

    write_reg(CFG_SPC, 24'($urandom_range(1, 128)));
    write_reg(CFG_DSTART, 24'd0);
    run_phase(0, 63, PHASE_ITEMS);
    wait_for_results();

    // A short stretch with the block disabled
    write_reg(CFG_ENABLE, 24'd0);
    run_phase(17, 17, 20);
    wait_for_results();

    write_reg(CFG_ENABLE, 24'd1);
    write_reg(CFG_SPC, 24'($urandom_range(1, 128)));
    write_reg(CFG_DSTART, 24'($urandom));
    run_phase(17, 17, PHASE_ITEMS);
    wait_for_results();
    repeat (8) @(posedge clk);

    $display("Run covered %0d input transactions and %0d results, %0d of them segments,",
             items_sent, sb.results_checked, sb.segments_seen);
    $display("over geometries with 0, 1, 128 and random sectors per cluster and four stall patterns.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d field errors, %0d results never seen", sb.errors, sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/fcw_pkg.sv
design/fcw_ram.sv
design/fat12_cluster_chain_walker.sv
design/fcw_checker.sv
tb/sv/fat_walk_check_pkg.sv
tb/sv/tb_top.sv
